>>> hw/rtl/histogram_fill_1d_2d_assert.svh
// assertion shorthands for the histogram engine, sampled on clk and disabled in reset
`ifndef HISTOGRAM_FILL_1D_2D_ASSERT_SVH
`define HISTOGRAM_FILL_1D_2D_ASSERT_SVH

// condition holds at every edge out of reset
`define HFF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define HFF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/hff_pkg.sv
`default_nettype none

package hff_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int BWIDTH_W    = 31;
    localparam int NBINS_W     = 13;
    localparam int RDBIN_W     = 12;
    localparam int OUT_W       = 32;
    localparam int CLASS_W     = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PROD_W      = 2 * NBINS_W;
    localparam int FLAT_W      = PROD_W + 1;
    localparam int DIV_STEPS   = SAMPLE_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam int MAX_BINS_DEF    = 4096;
    localparam int COUNT_WIDTH_DEF = 32;

    // command codes
    localparam logic CMD_FILL = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TWO_DIM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_LOW     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_X_NBINS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_WIDTH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_Y_NBINS   = 3'd6;

    // register reset values
    localparam logic [BWIDTH_W-1:0] RST_WIDTH   = 31'd1;
    localparam logic [NBINS_W-1:0]  RST_X_NBINS = 13'd4096;
    localparam logic [NBINS_W-1:0]  RST_Y_NBINS = 13'd1;

    typedef enum logic [CLASS_W-1:0] {
        CLS_BINNED = 2'd0,
        CLS_UNDER  = 2'd1,
        CLS_OVER   = 2'd2,
        CLS_READ   = 2'd3
    } hff_class_t;

    typedef struct packed {
        logic                busy;
        logic [SAMPLE_W-1:0] quot;
    } hff_div_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/hff_req_if.sv
`default_nettype none

interface hff_req_if import hff_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic [RDBIN_W-1:0]         read_bin;

    modport source (output valid, cmd, x_sample, y_sample, read_bin, input ready);
    modport sink   (input valid, cmd, x_sample, y_sample, read_bin, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hff_rsp_if.sv
`default_nettype none

interface hff_rsp_if import hff_pkg::*;;
    logic               valid;
    logic               ready;
    logic [OUT_W-1:0]   bin_count;
    logic [OUT_W-1:0]   entry_total;
    logic [OUT_W-1:0]   underflow_total;
    logic [OUT_W-1:0]   overflow_total;
    logic [CLASS_W-1:0] fill_class;

    modport source (output valid, bin_count, entry_total, underflow_total, overflow_total,
                    fill_class, input ready);
    modport sink   (input valid, bin_count, entry_total, underflow_total, overflow_total,
                    fill_class, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hff_cfg_if.sv
`default_nettype none

interface hff_cfg_if import hff_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/hff_ram.sv
`default_nettype none

module hff_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/hff_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module hff_div import hff_pkg::*; (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [SAMPLE_W-1:0] dividend,
    input  wire logic [BWIDTH_W-1:0] divisor,
    output hff_div_stat_t            stat
);

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [BWIDTH_W-1:0] rem_reg, rem_next;
    logic [BWIDTH_W-1:0] dsr_reg, dsr_next;
    logic [SAMPLE_W-1:0] q_reg, q_next;
    logic [SAMPLE_W-1:0] trial;
    logic                fits;

    always_comb
    begin
        trial     = {rem_reg, q_reg[SAMPLE_W-1]};
        fits      = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            q_next    = dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? BWIDTH_W'(trial - {1'b0, dsr_reg}) : BWIDTH_W'(trial);
            q_next    = {q_reg[SAMPLE_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_next;
            q_reg    <= q_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.quot = q_reg;

endmodule

`default_nettype wire

>>> hw/rtl/histogram_fill_1d_2d.sv
`default_nettype none

// Histogram engine for signed 32-bit samples in 1D or 2D mode. A fill item bumps the entry
// total and then either the underflow total, the overflow total, or one bin of the store; a
// read item returns one bin and the three totals. Exactly one result item leaves per input
// item, in order. Items are worked one at a time: a read item reads its bin on accept and
// goes straight to the result step; a binned fill item passes the two bit-serial axis
// dividers, which run side by side, then classification and the 2D flat-index multiply,
// then the flat-index add and bin read and last the saturating write-back; a fill item that
// the dividers already mark as underflow or overflow skips the multiply and the bin read.
// The write-back step waits while an earlier result is still held, so a stalled result side
// adds its stall cycles. The result waits in an output register, so the next item can be
// accepted while it is still held. After reset the bin store is cleared by a pass over its
// MAX_BINS entries, one a cycle, during which no item is accepted; configuration writes are
// taken at any time and must only happen while the engine is idle. Counters saturate at all
// ones of COUNT_WIDTH bits and show their low 32 bits.
module histogram_fill_1d_2d import hff_pkg::*; #(
    parameter int MAX_BINS    = MAX_BINS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hff_req_if.sink   req,
    hff_rsp_if.source rsp,
    hff_cfg_if.sink   cfg
);

    localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_MUL,
        S_RD
    } state_t;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // control and item state
    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    hff_class_t            cls_reg, cls_next;
    logic                  hit_reg, hit_next;
    logic                  x_under_reg, x_under_next;
    logic                  y_under_reg, y_under_next;
    logic [NBINS_W-1:0]    xb_reg, xb_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;

    // configuration registers
    logic                        two_dim_reg, two_dim_next;
    logic signed [SAMPLE_W-1:0]  x_low_reg, x_low_next;
    logic [BWIDTH_W-1:0]         x_width_reg, x_width_next;
    logic [NBINS_W-1:0]          x_nbins_reg, x_nbins_next;
    logic signed [SAMPLE_W-1:0]  y_low_reg, y_low_next;
    logic [BWIDTH_W-1:0]         y_width_reg, y_width_next;
    logic [NBINS_W-1:0]          y_nbins_reg, y_nbins_next;

    // totals
    logic [COUNT_WIDTH-1:0] entry_cnt_reg, entry_cnt_next;
    logic [COUNT_WIDTH-1:0] under_cnt_reg, under_cnt_next;
    logic [COUNT_WIDTH-1:0] over_cnt_reg, over_cnt_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_bin_reg, out_bin_next;
    logic [OUT_W-1:0] out_entry_reg, out_entry_next;
    logic [OUT_W-1:0] out_under_reg, out_under_next;
    logic [OUT_W-1:0] out_over_reg, out_over_next;
    hff_class_t       out_class_reg, out_class_next;

    // datapath
    logic                   accept;
    logic                   div_start;
    logic [SAMPLE_W:0]      dx, dy;
    logic [BWIDTH_W-1:0]    x_dsr, y_dsr;
    hff_div_stat_t          xstat, ystat;
    logic                   x_over, y_over;
    logic [NBINS_W-1:0]     yb;
    logic [FLAT_W-1:0]      flat;
    logic                   ram_we, ram_re;
    logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;
    logic [COUNT_WIDTH-1:0] bin_new;
    logic                   out_free;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    assign div_start = accept && (req.cmd == CMD_FILL);

    // offset from the lower edge, one bit wider so the sign shows underflow
    assign dx    = {req.x_sample[SAMPLE_W-1], req.x_sample} - {x_low_reg[SAMPLE_W-1], x_low_reg};
    assign dy    = {req.y_sample[SAMPLE_W-1], req.y_sample} - {y_low_reg[SAMPLE_W-1], y_low_reg};
    // zero width behaves as width one
    assign x_dsr = (x_width_reg == '0) ? BWIDTH_W'(1) : x_width_reg;
    assign y_dsr = (y_width_reg == '0) ? BWIDTH_W'(1) : y_width_reg;

    hff_div u_xdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dx[SAMPLE_W-1:0]),
        .divisor  (x_dsr),
        .stat     (xstat)
    );

    hff_div u_ydiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dy[SAMPLE_W-1:0]),
        .divisor  (y_dsr),
        .stat     (ystat)
    );

    hff_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // axis classification once the quotients are ready; y only counts in 2D mode
    assign x_over = xstat.quot >= SAMPLE_W'(x_nbins_reg);
    assign y_over = two_dim_reg && (ystat.quot >= SAMPLE_W'(y_nbins_reg));
    assign yb     = two_dim_reg ? ystat.quot[NBINS_W-1:0] : '0;
    assign flat   = FLAT_W'(xb_reg) + FLAT_W'(prod_reg);

    assign bin_new  = sat_inc(ram_rdata);
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        cls_next       = cls_reg;
        hit_next       = hit_reg;
        x_under_next   = x_under_reg;
        y_under_next   = y_under_reg;
        xb_next        = xb_reg;
        prod_next      = prod_reg;
        addr_next      = addr_reg;
        two_dim_next   = two_dim_reg;
        x_low_next     = x_low_reg;
        x_width_next   = x_width_reg;
        x_nbins_next   = x_nbins_reg;
        y_low_next     = y_low_reg;
        y_width_next   = y_width_reg;
        y_nbins_next   = y_nbins_reg;
        entry_cnt_next = entry_cnt_reg;
        under_cnt_next = under_cnt_reg;
        over_cnt_next  = over_cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_bin_next   = out_bin_reg;
        out_entry_next = out_entry_reg;
        out_under_next = out_under_reg;
        out_over_next  = out_over_reg;
        out_class_next = out_class_reg;
        ram_we         = 1'b0;
        ram_waddr      = addr_reg;
        ram_wdata      = bin_new;
        ram_re         = 1'b0;
        ram_raddr      = ADDR_W'(flat);

        // configuration writes, index past the list is dropped
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TWO_DIM: two_dim_next = cfg.data[0];
                REG_X_LOW:   x_low_next   = cfg.data;
                REG_X_WIDTH: x_width_next = cfg.data[BWIDTH_W-1:0];
                REG_X_NBINS: x_nbins_next = cfg.data[NBINS_W-1:0];
                REG_Y_LOW:   y_low_next   = cfg.data;
                REG_Y_WIDTH: y_width_next = cfg.data[BWIDTH_W-1:0];
                REG_Y_NBINS: y_nbins_next = cfg.data[NBINS_W-1:0];
                default:     ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // zero the store one entry a cycle
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(MAX_BINS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ram_raddr = ADDR_W'(req.read_bin);
                if (accept)
                begin
                    if (req.cmd == CMD_READ)
                    begin
                        hit_next   = 32'(req.read_bin) < 32'(MAX_BINS);
                        ram_re     = hit_next;
                        cls_next   = CLS_READ;
                        state_next = S_RD;
                    end
                    else
                    begin
                        x_under_next = dx[SAMPLE_W];
                        y_under_next = dy[SAMPLE_W];
                        state_next   = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (!xstat.busy)
                begin
                    hit_next = 1'b0;
                    // underflow on either axis wins over overflow
                    if (x_under_reg || (two_dim_reg && y_under_reg))
                    begin
                        cls_next   = CLS_UNDER;
                        state_next = S_RD;
                    end
                    else if (x_over || y_over)
                    begin
                        cls_next   = CLS_OVER;
                        state_next = S_RD;
                    end
                    else
                    begin
                        xb_next    = xstat.quot[NBINS_W-1:0];
                        prod_next  = PROD_W'(yb) * PROD_W'(x_nbins_reg);
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                // flat index beyond the store counts as overflow
                if (32'(flat) < 32'(MAX_BINS))
                begin
                    hit_next  = 1'b1;
                    ram_re    = 1'b1;
                    addr_next = ADDR_W'(flat);
                    cls_next  = CLS_BINNED;
                end
                else
                begin
                    cls_next = CLS_OVER;
                end
                state_next = S_RD;
            end
            S_RD:
            begin
                if (out_free)
                begin
                    if (cls_reg != CLS_READ)
                    begin
                        entry_cnt_next = sat_inc(entry_cnt_reg);
                    end
                    if (cls_reg == CLS_UNDER)
                    begin
                        under_cnt_next = sat_inc(under_cnt_reg);
                    end
                    if (cls_reg == CLS_OVER)
                    begin
                        over_cnt_next = sat_inc(over_cnt_reg);
                    end
                    ram_we = (cls_reg == CLS_BINNED);
                    if (cls_reg == CLS_BINNED)
                    begin
                        out_bin_next = OUT_W'(bin_new);
                    end
                    else if (hit_reg)
                    begin
                        out_bin_next = OUT_W'(ram_rdata);
                    end
                    else
                    begin
                        out_bin_next = '0;
                    end
                    out_valid_next = 1'b1;
                    out_entry_next = OUT_W'(entry_cnt_next);
                    out_under_next = OUT_W'(under_cnt_next);
                    out_over_next  = OUT_W'(over_cnt_next);
                    out_class_next = cls_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            cls_reg       <= CLS_READ;
            hit_reg       <= 1'b0;
            x_under_reg   <= 1'b0;
            y_under_reg   <= 1'b0;
            xb_reg        <= '0;
            prod_reg      <= '0;
            addr_reg      <= '0;
            two_dim_reg   <= 1'b0;
            x_low_reg     <= '0;
            x_width_reg   <= RST_WIDTH;
            x_nbins_reg   <= RST_X_NBINS;
            y_low_reg     <= '0;
            y_width_reg   <= RST_WIDTH;
            y_nbins_reg   <= RST_Y_NBINS;
            entry_cnt_reg <= '0;
            under_cnt_reg <= '0;
            over_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_bin_reg   <= '0;
            out_entry_reg <= '0;
            out_under_reg <= '0;
            out_over_reg  <= '0;
            out_class_reg <= CLS_READ;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            cls_reg       <= cls_next;
            hit_reg       <= hit_next;
            x_under_reg   <= x_under_next;
            y_under_reg   <= y_under_next;
            xb_reg        <= xb_next;
            prod_reg      <= prod_next;
            addr_reg      <= addr_next;
            two_dim_reg   <= two_dim_next;
            x_low_reg     <= x_low_next;
            x_width_reg   <= x_width_next;
            x_nbins_reg   <= x_nbins_next;
            y_low_reg     <= y_low_next;
            y_width_reg   <= y_width_next;
            y_nbins_reg   <= y_nbins_next;
            entry_cnt_reg <= entry_cnt_next;
            under_cnt_reg <= under_cnt_next;
            over_cnt_reg  <= over_cnt_next;
            out_valid_reg <= out_valid_next;
            out_bin_reg   <= out_bin_next;
            out_entry_reg <= out_entry_next;
            out_under_reg <= out_under_next;
            out_over_reg  <= out_over_next;
            out_class_reg <= out_class_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.bin_count       = out_bin_reg;
    assign rsp.entry_total     = out_entry_reg;
    assign rsp.underflow_total = out_under_reg;
    assign rsp.overflow_total  = out_over_reg;
    assign rsp.fill_class      = out_class_reg;

    `include "histogram_fill_1d_2d_assert.svh"

    // every underflow or overflow fill is also an entry
    `HFF_ASSERT_ALWAYS(a_entry_ge_under, entry_cnt_reg >= under_cnt_reg, "underflow total above entries")
    `HFF_ASSERT_ALWAYS(a_entry_ge_over, entry_cnt_reg >= over_cnt_reg, "overflow total above entries")
    // both axis dividers start together and must finish together
    `HFF_ASSERT_IMPL(a_div_lockstep, (state_reg == S_DIV) && !xstat.busy, !ystat.busy, "axis dividers out of step")
    // a new result only appears right after the write-back step
    `HFF_ASSERT_IMPL(a_result_from_rd, $rose(out_valid_reg), $past(state_reg == S_RD), "result without write-back step")

endmodule

`default_nettype wire
